FILE: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int MaxPattern = 16;
	localparam int MaxReplace = 16;
	localparam int CountW     = $clog2(MaxPattern + 1);
	localparam int IdxW       = $clog2(MaxPattern);
	localparam int RIdxW      = $clog2(MaxReplace + 1);
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 64;
	localparam int LenW       = 5;

	localparam logic [7:0] Newline = 8'h0A;

	typedef enum logic [CfgIdxW-1:0] {
		CfgPatternLen = 3'd0,
		CfgPatternLo  = 3'd1,
		CfgPatternHi  = 3'd2,
		CfgReplaceLen = 3'd3,
		CfgReplaceLo  = 3'd4,
		CfgReplaceHi  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       stream_done;
	} out_word_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		SeqIdle,
		SeqPre,
		SeqCheck,
		SeqRepl,
		SeqFlush,
		SeqFin
	} seq_state_t;

endpackage

FILE: src/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One pending-byte cell: holds a byte, shifts from its neighbor, compares
// against the pattern byte at its position.
// ----------------------------------------------------------------------------
module sfr_cell import sfr_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       sel,
	input  logic [7:0] load_char,
	input  logic [7:0] next_char,
	input  logic [7:0] pat_char,
	input  logic       in_use,
	output logic [7:0] cell_char,
	output logic       hit
);

	logic [7:0] char_q;

	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			char_q <= load_char;
		end else if (ctrl.shift) begin
			char_q <= next_char;
		end
	end

	assign cell_char = char_q;
	assign hit       = !in_use || (char_q == pat_char);

endmodule

FILE: src/sfr_seq.sv
// ----------------------------------------------------------------------------
// sfr_seq
// Sequencer: accepts words, drives the cell chain, emits bytes through a
// one-byte hold stage and an output register.
// ----------------------------------------------------------------------------
module sfr_seq import sfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_data,
	input  logic [LenW-1:0]   plen,
	input  logic [LenW-1:0]   rlen,
	input  logic [7:0]        repl_char,
	input  logic [7:0]        head_char,
	input  logic              all_hit,
	output cell_ctrl_t        ctrl,
	output logic [7:0]        load_char,
	output logic [CountW-1:0] count,
	output logic [RIdxW-1:0]  repl_idx
);

	seq_state_t        state_q, state_d;
	logic [CountW-1:0] count_q, count_d;
	logic [RIdxW-1:0]  repl_idx_q, repl_idx_d;
	logic              hold_valid_q, hold_valid_d;
	logic [7:0]        hold_char_q, hold_char_d;
	logic              out_valid_q;
	out_word_t         out_word_q;
	logic [7:0]        char_q;
	logic              eos_q;
	logic              accept;
	logic              can_push;
	logic              stall;
	logic              emit;
	logic [7:0]        emit_char;
	logic              push;
	out_word_t         push_word;
	logic [7:0]        end_state_char;
	seq_state_t        after_match;

	assign accept   = in_ready && in_valid;
	assign can_push = !out_valid_q || out_ready;
	assign stall    = hold_valid_q && !can_push;

	assign end_state_char = char_q;
	assign after_match    = (end_state_char == Newline) ? SeqFlush : SeqFin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SeqIdle;
			count_q      <= '0;
			repl_idx_q   <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			repl_idx_q   <= repl_idx_d;
			hold_valid_q <= hold_valid_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hold_char_q <= hold_char_d;
		if (push) begin
			out_word_q <= push_word;
		end
		if (accept) begin
			char_q <= in_data.in_char;
			eos_q  <= in_data.end_of_stream;
		end
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		repl_idx_d   = repl_idx_q;
		hold_valid_d = hold_valid_q;
		hold_char_d  = hold_char_q;
		in_ready     = 1'b0;
		ctrl         = '0;
		load_char    = char_q;
		emit         = 1'b0;
		emit_char    = head_char;
		push         = 1'b0;
		push_word    = '{out_char: hold_char_q, run_last: 1'b0, stream_done: 1'b0};

		case (state_q)
			SeqIdle: begin
				in_ready  = 1'b1;
				load_char = in_data.in_char;
				if (in_valid) begin
					if (in_data.end_of_stream) begin
						state_d = SeqFlush;
					end else if (count_q >= plen) begin
						state_d = SeqPre;
					end else begin
						ctrl.load = 1'b1;
						count_d   = count_q + 1'b1;
						state_d   = SeqCheck;
					end
				end
			end
			SeqPre: begin
				if (count_q == '0) begin
					ctrl.load = 1'b1;
					count_d   = CountW'(1);
					state_d   = SeqCheck;
				end else begin
					emit = 1'b1;
					if (!stall) begin
						ctrl.shift = 1'b1;
						count_d    = count_q - 1'b1;
					end
				end
			end
			SeqCheck: begin
				if (all_hit) begin
					if (count_q == plen) begin
						count_d    = '0;
						repl_idx_d = '0;
						state_d    = SeqRepl;
					end else begin
						state_d = after_match;
					end
				end else begin
					emit = 1'b1;
					if (!stall) begin
						ctrl.shift = 1'b1;
						count_d    = count_q - 1'b1;
					end
				end
			end
			SeqRepl: begin
				if (repl_idx_q == rlen) begin
					state_d = after_match;
				end else begin
					emit      = 1'b1;
					emit_char = repl_char;
					if (!stall) begin
						repl_idx_d = repl_idx_q + 1'b1;
					end
				end
			end
			SeqFlush: begin
				if (count_q == '0) begin
					state_d = SeqFin;
				end else begin
					emit = 1'b1;
					if (!stall) begin
						ctrl.shift = 1'b1;
						count_d    = count_q - 1'b1;
					end
				end
			end
			SeqFin: begin
				if (!hold_valid_q) begin
					state_d = SeqIdle;
				end else if (can_push) begin
					push         = 1'b1;
					push_word    = '{out_char: hold_char_q, run_last: 1'b1,
						stream_done: eos_q};
					hold_valid_d = 1'b0;
					state_d      = SeqIdle;
				end
			end
			default: begin
				state_d = SeqIdle;
			end
		endcase

		// a new byte pushes the held one out; the held one is final only in SeqFin
		if (emit && !stall) begin
			if (hold_valid_q) begin
				push = 1'b1;
			end
			hold_char_d  = emit_char;
			hold_valid_d = 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;
	assign count     = count_q;
	assign repl_idx  = repl_idx_q;

endmodule

FILE: src/stream_find_replace_core.sv
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Streaming find-and-replace: a chain of pending-byte cells matched against
// the configured pattern, with replacement and per-line flush.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_data  (in_char, end_of_stream)
//   out      out  out_valid / out_ready  out_data (out_char, run_last,
//                                                  stream_done)
//   cfg      in   cfg_en                 cfg_index, cfg_data
//
// One word at a time: a byte that emits nothing passes accept, chain check
// and finish; a replacement, a line flush or a flush ahead of a shortened
// pattern passes through SeqRepl, SeqFlush or SeqPre as well.
// The sequencer steps the cell chain one shift per cycle while not stalled.
// Output bytes pass a one-byte hold stage so the last byte can be marked.
// A stalled output holds the sequencer; in_ready is high only between words.
// Reset clears control and config state (pattern len 1); no clearing pass.
// ----------------------------------------------------------------------------
module stream_find_replace_core import sfr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_word_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_word_t           out_data,
	input  logic                cfg_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic [LenW-1:0]     pattern_len_q;
	logic [CfgDataW-1:0] pattern_lo_q;
	logic [CfgDataW-1:0] pattern_hi_q;
	logic [LenW-1:0]     replace_len_q;
	logic [CfgDataW-1:0] replace_lo_q;
	logic [CfgDataW-1:0] replace_hi_q;

	logic [LenW-1:0]              plen;
	logic [LenW-1:0]              rlen;
	logic [MaxPattern-1:0][7:0]   pat_bytes;
	logic [MaxReplace-1:0][7:0]   repl_bytes;
	logic [MaxPattern-1:0][7:0]   cell_chars;
	logic [MaxPattern-1:0][7:0]   next_chars;
	logic [MaxPattern-1:0]        hits;
	cell_ctrl_t                   ctrl;
	logic [7:0]                   load_char;
	logic [CountW-1:0]            count;
	logic [RIdxW-1:0]             repl_idx;
	logic [7:0]                   repl_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q <= LenW'(1);
			pattern_lo_q  <= '0;
			pattern_hi_q  <= '0;
			replace_len_q <= '0;
			replace_lo_q  <= '0;
			replace_hi_q  <= '0;
		end else if (cfg_en) begin
			case (cfg_reg_t'(cfg_index))
				CfgPatternLen: pattern_len_q <= cfg_data[LenW-1:0];
				CfgPatternLo:  pattern_lo_q  <= cfg_data;
				CfgPatternHi:  pattern_hi_q  <= cfg_data;
				CfgReplaceLen: replace_len_q <= cfg_data[LenW-1:0];
				CfgReplaceLo:  replace_lo_q  <= cfg_data;
				CfgReplaceHi:  replace_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pattern_len_q == '0) begin
			plen = LenW'(1);
		end else if (pattern_len_q > LenW'(MaxPattern)) begin
			plen = LenW'(MaxPattern);
		end else begin
			plen = pattern_len_q;
		end
		if (replace_len_q > LenW'(MaxReplace)) begin
			rlen = LenW'(MaxReplace);
		end else begin
			rlen = replace_len_q;
		end
	end

	assign pat_bytes  = {pattern_hi_q, pattern_lo_q};
	assign repl_bytes = {replace_hi_q, replace_lo_q};
	assign repl_char  = repl_bytes[repl_idx[IdxW-1:0]];

	genvar gi;
	generate
		for (gi = 0; gi < MaxPattern; gi++) begin : g_cell
			if (gi == MaxPattern - 1) begin : g_tail
				assign next_chars[gi] = cell_chars[gi];
			end else begin : g_body
				assign next_chars[gi] = cell_chars[gi+1];
			end

			sfr_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.sel       (count[IdxW-1:0] == IdxW'(gi)),
				.load_char (load_char),
				.next_char (next_chars[gi]),
				.pat_char  (pat_bytes[gi]),
				.in_use    (CountW'(gi) < count),
				.cell_char (cell_chars[gi]),
				.hit       (hits[gi])
			);
		end
	endgenerate

	sfr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.plen      (plen),
		.rlen      (rlen),
		.repl_char (repl_char),
		.head_char (cell_chars[0]),
		.all_hit   (&hits),
		.ctrl      (ctrl),
		.load_char (load_char),
		.count     (count),
		.repl_idx  (repl_idx)
	);

endmodule
